// File: sv/awss_pkg.sv
`default_nettype none

package awss_pkg;

	// cordic depth and arctangent table, atan(2^-i) in q0.30
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN = 24;
	localparam int ATAN_W = 30;
	localparam logic [ATAN_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

	// steering angle limit, 1.5 rad in q1.15
	localparam logic [15:0] ANGLE_MAX = 16'd49152;

	// register reset values
	localparam logic [11:0] WHEELBASE_RST = 12'd200;
	localparam logic [11:0] TREAD_RST = 12'd160;

	// register indexes
	typedef enum logic [0:0] {
		REG_WHEELBASE = 1'b0,
		REG_TREAD     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]        steer_angle;
		logic signed [15:0] target_velocity;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] inner_velocity;
		logic signed [15:0] outer_velocity;
		logic               saturated;
	} out_beat_t;

endpackage

`default_nettype wire

// File: sv/ackermann_wheel_speed_split.sv
`default_nettype none

// channel  direction  handshake           payload
// in       sink       in_valid/in_stall   in_data   (steer_angle, target_velocity)
// out      source     out_valid/out_stall out_data  (inner/outer_velocity, saturated)
// cfg      sink       cfg_wen             cfg_index, cfg_wdata
//
// one beat per cycle in while in_stall is low
// the pipeline holds one cordic iteration per stage and one quotient bit per stage
// arst_n clears the stage valid bits and loads the register defaults
// out_stall holds only occupied stages; bubbles still close up, in_stall rises
// only when every stage holds a beat

module ackermann_wheel_speed_split (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire awss_pkg::in_beat_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output awss_pkg::out_beat_t       out_data,
	input  wire logic                 cfg_wen,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [11:0]          cfg_wdata
);
	import awss_pkg::*;

	localparam int CW = 33;           // cordic x/y
	localparam int ZW = 34;           // cordic angle accumulator
	localparam int DENW = 44;
	localparam int TSW = 46;
	localparam int NW = 48;
	localparam int MW = NW - 1;
	localparam int LOW = 24;
	localparam int DW = 64;
	localparam int QW = 16;
	localparam int ST_CORD0 = 1;
	localparam int ST_DEN = CORDIC_STEPS + 1;
	localparam int ST_NUM = ST_DEN + 1;
	localparam int ST_PP = ST_NUM + 1;
	localparam int ST_DVD = ST_PP + 1;
	localparam int ST_OVF = ST_DVD + 1;
	localparam int ST_DIV0 = ST_OVF + 1;
	localparam int ST_OUT = ST_DIV0 + QW;
	localparam int NS = ST_OUT + 1;
	localparam logic signed [CW-1:0] X_INIT = CW'(64'd1 << 30);

	logic [11:0] wheelbase_q, tread_q;
	logic [NS-1:0] vld_q, adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= WHEELBASE_RST;
			tread_q <= TREAD_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_WHEELBASE: wheelbase_q <= cfg_wdata;
				REG_TREAD:     tread_q <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// stage advance, a stage moves when empty or when its successor moves
	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_stall = !adv[0];
	assign out_valid = vld_q[NS-1];

	// stage 1: clamp angle, scale to q4.30
	logic signed [ZW-1:0] z_s1;
	logic zero_s1;
	logic signed [15:0] v_s1;
	logic [15:0] ang_c;

	assign ang_c = (in_data.steer_angle > ANGLE_MAX) ? ANGLE_MAX : in_data.steer_angle;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			z_s1 <= $signed({3'b000, ang_c, 15'b0});
			zero_s1 <= (in_data.steer_angle == 16'd0);
			v_s1 <= in_data.target_velocity;
		end
	end

	// cordic rotation, one iteration per stage
	logic signed [CW-1:0] x_s2 [CORDIC_STEPS];
	logic signed [CW-1:0] y_s2 [CORDIC_STEPS];
	logic signed [ZW-1:0] z_s2 [CORDIC_STEPS];
	logic zero_s2 [CORDIC_STEPS];
	logic signed [15:0] v_s2 [CORDIC_STEPS];

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi, at;
		logic zri;
		logic signed [15:0] vi;

		if (g == 0) begin : g_first
			assign xi = X_INIT;
			assign yi = '0;
			assign zi = z_s1;
			assign zri = zero_s1;
			assign vi = v_s1;
		end else begin : g_next
			assign xi = x_s2[g-1];
			assign yi = y_s2[g-1];
			assign zi = z_s2[g-1];
			assign zri = zero_s2[g-1];
			assign vi = v_s2[g-1];
		end

		assign at = $signed({{(ZW-ATAN_W){1'b0}}, ATAN_Q30[g]});

		always_ff @(posedge clk) begin
			if (adv[ST_CORD0+g]) begin
				if (!zi[ZW-1]) begin
					x_s2[g] <= xi - (yi >>> g);
					y_s2[g] <= yi + (xi >>> g);
					z_s2[g] <= zi - at;
				end else begin
					x_s2[g] <= xi + (yi >>> g);
					y_s2[g] <= yi - (xi >>> g);
					z_s2[g] <= zi + at;
				end
				zero_s2[g] <= zri;
				v_s2[g] <= vi;
			end
		end
	end

	// stage 3: den = 2*w*cos, ts = t*sin
	logic [30:0] x_pos;
	logic signed [CW-1:0] y_use;
	logic [11:0] w_eff;
	logic [DENW-2:0] wx;
	logic signed [TSW-1:0] ts_c;
	logic [DENW-1:0] den_s3;
	logic signed [TSW-1:0] ts_s3;
	logic signed [15:0] v_s3;

	assign x_pos = (x_s2[CORDIC_STEPS-1][CW-1] || x_s2[CORDIC_STEPS-1] == '0)
		? 31'd1 : x_s2[CORDIC_STEPS-1][30:0];
	assign y_use = zero_s2[CORDIC_STEPS-1] ? '0 : y_s2[CORDIC_STEPS-1];
	assign w_eff = (wheelbase_q == 12'd0) ? 12'd1 : wheelbase_q;
	assign wx = (DENW-1)'(w_eff) * (DENW-1)'(x_pos);
	assign ts_c = TSW'($signed({1'b0, tread_q})) * TSW'(y_use);

	always_ff @(posedge clk) begin
		if (adv[ST_DEN]) begin
			den_s3 <= {wx, 1'b0};
			ts_s3 <= ts_c;
			v_s3 <= v_s2[CORDIC_STEPS-1];
		end
	end

	// stage 4: numerator factors den -/+ ts as magnitude and sign, lane 0 inner
	logic signed [NW-1:0] n_c [2];
	logic [MW-1:0] mag_s4 [2];
	logic neg_s4 [2];
	logic [15:0] av_s4;
	logic [DENW-1:0] den_s4;

	assign n_c[0] = $signed({{(NW-DENW){1'b0}}, den_s3}) - NW'(ts_s3);
	assign n_c[1] = $signed({{(NW-DENW){1'b0}}, den_s3}) + NW'(ts_s3);

	always_ff @(posedge clk) begin
		if (adv[ST_NUM]) begin
			for (int l = 0; l < 2; l++) begin
				mag_s4[l] <= n_c[l][NW-1] ? MW'(-n_c[l]) : n_c[l][MW-1:0];
				neg_s4[l] <= v_s3[15] ^ n_c[l][NW-1];
			end
			av_s4 <= v_s3[15] ? 16'(-v_s3) : 16'(v_s3);
			den_s4 <= den_s3;
		end
	end

	// stage 5: |v| * |n| in two partial products per lane
	logic [16+LOW-1:0] plo_s5 [2];
	logic [16+MW-LOW-1:0] phi_s5 [2];
	logic neg_s5 [2];
	logic [DENW-1:0] den_s5;

	always_ff @(posedge clk) begin
		if (adv[ST_PP]) begin
			for (int l = 0; l < 2; l++) begin
				plo_s5[l] <= (16+LOW)'(av_s4) * (16+LOW)'(mag_s4[l][LOW-1:0]);
				phi_s5[l] <= (16+MW-LOW)'(av_s4) * (16+MW-LOW)'(mag_s4[l][MW-1:LOW]);
				neg_s5[l] <= neg_s4[l];
			end
			den_s5 <= den_s4;
		end
	end

	// stage 6: dividend with half divisor for round to nearest
	logic [DW-1:0] dvd_s6 [2];
	logic neg_s6 [2];
	logic [DENW-1:0] den_s6;

	always_ff @(posedge clk) begin
		if (adv[ST_DVD]) begin
			for (int l = 0; l < 2; l++) begin
				dvd_s6[l] <= (DW'(phi_s5[l]) << LOW) + DW'(plo_s5[l]) + DW'(den_s5 >> 1);
				neg_s6[l] <= neg_s5[l];
			end
			den_s6 <= den_s5;
		end
	end

	// stage 7: quotient beyond 16 bits is a saturation
	logic [DW-1:0] rem_s7 [2];
	logic ovf_s7 [2];
	logic neg_s7 [2];
	logic [DENW-1:0] den_s7;

	always_ff @(posedge clk) begin
		if (adv[ST_OVF]) begin
			for (int l = 0; l < 2; l++) begin
				ovf_s7[l] <= dvd_s6[l] >= (DW'(den_s6) << QW);
				rem_s7[l] <= dvd_s6[l];
				neg_s7[l] <= neg_s6[l];
			end
			den_s7 <= den_s6;
		end
	end

	// restoring division, one quotient bit per stage, msb first
	logic [DW-1:0] rem_s8 [QW][2];
	logic [QW-1:0] q_s8 [QW][2];
	logic ovf_s8 [QW][2];
	logic neg_s8 [QW][2];
	logic [DENW-1:0] den_s8 [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [DW-1:0] ri [2];
		logic [QW-1:0] qi [2];
		logic oi [2];
		logic ni [2];
		logic [DENW-1:0] di;
		logic [DW-1:0] dsh;

		if (j == 0) begin : g_first
			assign ri = rem_s7;
			assign qi = '{default: '0};
			assign oi = ovf_s7;
			assign ni = neg_s7;
			assign di = den_s7;
		end else begin : g_next
			assign ri = rem_s8[j-1];
			assign qi = q_s8[j-1];
			assign oi = ovf_s8[j-1];
			assign ni = neg_s8[j-1];
			assign di = den_s8[j-1];
		end

		assign dsh = DW'(di) << (QW - 1 - j);

		always_ff @(posedge clk) begin
			if (adv[ST_DIV0+j]) begin
				for (int l = 0; l < 2; l++) begin
					if (ri[l] >= dsh) begin
						rem_s8[j][l] <= ri[l] - dsh;
						q_s8[j][l] <= qi[l] | (QW'(1) << (QW - 1 - j));
					end else begin
						rem_s8[j][l] <= ri[l];
						q_s8[j][l] <= qi[l];
					end
					ovf_s8[j][l] <= oi[l];
					neg_s8[j][l] <= ni[l];
				end
				den_s8[j] <= di;
			end
		end
	end

	// output stage: sign, saturate, flag
	logic [15:0] res_c [2];
	logic sat_c [2];
	out_beat_t out_s9;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sat_c[l] = ovf_s8[QW-1][l] ||
				(neg_s8[QW-1][l] ? (q_s8[QW-1][l] > 16'd32768) : (q_s8[QW-1][l] > 16'd32767));
			if (sat_c[l]) begin
				res_c[l] = neg_s8[QW-1][l] ? 16'h8000 : 16'h7fff;
			end else begin
				res_c[l] = neg_s8[QW-1][l] ? 16'(-q_s8[QW-1][l]) : q_s8[QW-1][l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			out_s9.inner_velocity <= $signed(res_c[0]);
			out_s9.outer_velocity <= $signed(res_c[1]);
			out_s9.saturated <= sat_c[0] || sat_c[1];
		end
	end

	assign out_data = out_s9;

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled while a stage is empty");

	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled with output free");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.saturated) |->
			(out_data.inner_velocity == 16'sh7fff || out_data.inner_velocity == 16'sh8000 ||
			 out_data.outer_velocity == 16'sh7fff || out_data.outer_velocity == 16'sh8000))
		else $error("saturation flag without a clipped speed");

	a_cfg_tread: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wen && cfg_index == REG_TREAD) |=> tread_q == $past(cfg_wdata))
		else $error("tread write lost");

endmodule

`default_nettype wire
